### rtl/speaker_channel_mix_accumulate_top_defines.svh
// assertion macros shared by the mixer rtl
`ifndef SPEAKER_CHANNEL_MIX_ACCUMULATE_TOP_DEFINES_SVH
`define SPEAKER_CHANNEL_MIX_ACCUMULATE_TOP_DEFINES_SVH

// checked while out of reset
`define SCMA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// checked at every edge, reset included
`define SCMA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

### rtl/scma_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package scma_pkg;

  // sample format and lane count
  localparam int unsigned SAMPLE_BITS  = 24;
  localparam int unsigned LANES        = 6;
  localparam int unsigned MAX_CHANNELS = 6;
  localparam int unsigned CNT_BITS     = 3;

  // q1.15 gain for sqrt(0.5); the half and quarter gains are shifts
  localparam int unsigned GAIN_BITS      = 16;
  localparam int unsigned GAIN_FRAC_BITS = 15;
  localparam logic signed [GAIN_BITS-1:0] GAIN_SQRT_HALF = 16'sd23170;

  // configuration register map
  localparam int unsigned ADDR_BITS = 4;
  localparam int unsigned DATA_BITS = 32;
  localparam logic [1:0] REG_SRC_COUNT = 2'd0;
  localparam logic [1:0] REG_DST_COUNT = 2'd1;
  localparam logic [1:0] REG_MIX_MODE  = 2'd2;

  localparam logic [CNT_BITS-1:0] SRC_COUNT_RST = 3'd2;
  localparam logic [CNT_BITS-1:0] DST_COUNT_RST = 3'd2;

  // mixing matrix selected by the channel counts
  typedef enum logic [3:0] {
    MIX_DISCRETE = 4'd0,
    MIX_UP_1_2   = 4'd1,
    MIX_UP_1_6   = 4'd2,
    MIX_UP_4_6   = 4'd3,
    MIX_DN_2_1   = 4'd4,
    MIX_DN_4_1   = 4'd5,
    MIX_DN_6_1   = 4'd6,
    MIX_DN_4_2   = 4'd7,
    MIX_DN_6_2   = 4'd8,
    MIX_DN_6_4   = 4'd9
  } mix_sel_e;

  typedef struct packed {
    mix_sel_e            sel;
    logic [CNT_BITS-1:0] n_disc;
    logic [CNT_BITS-1:0] n_dst;
  } mix_ctrl_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] src_s0;
    logic signed [SAMPLE_BITS-1:0] src_s1;
    logic signed [SAMPLE_BITS-1:0] src_s2;
    logic signed [SAMPLE_BITS-1:0] src_s3;
    logic signed [SAMPLE_BITS-1:0] src_s4;
    logic signed [SAMPLE_BITS-1:0] src_s5;
    logic signed [SAMPLE_BITS-1:0] dst_s0;
    logic signed [SAMPLE_BITS-1:0] dst_s1;
    logic signed [SAMPLE_BITS-1:0] dst_s2;
    logic signed [SAMPLE_BITS-1:0] dst_s3;
    logic signed [SAMPLE_BITS-1:0] dst_s4;
    logic signed [SAMPLE_BITS-1:0] dst_s5;
  } in_word_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] out_s0;
    logic signed [SAMPLE_BITS-1:0] out_s1;
    logic signed [SAMPLE_BITS-1:0] out_s2;
    logic signed [SAMPLE_BITS-1:0] out_s3;
    logic signed [SAMPLE_BITS-1:0] out_s4;
    logic signed [SAMPLE_BITS-1:0] out_s5;
    logic                          clipped;
  } out_word_t;

endpackage

`default_nettype wire

### rtl/speaker_channel_mix_accumulate_top.sv
`timescale 1ns / 1ps
`default_nettype none

// speaker channel mix and accumulate
//
// adds one source frame of up to six channels into a destination frame.
// input word: src_s0..src_s5 and dst_s0..dst_s5, taken at an edge with
// start high and busy low. busy stays low, so a word may enter every cycle.
// result word: out_s0..out_s5 and clipped, shown for one cycle while
// out_valid_o is high; the receiver cannot hold it off and needs none.
// a five stage pipe carries each word from accept to the strobe, one word
// per clock: config decode and capture, sqrt(0.5) multiply, rounding of
// scaled terms, matrix select with pair sums, final sum with saturation.
// the apb port sets source count, destination count and mix mode at 0, 4
// and 8; write it only while the pipe is empty. pready is always high.
// reset clears the pipe valid bits and loads counts 2, 2 and speaker mode.
// lanes at or beyond the destination count read zero and never clip.

module speaker_channel_mix_accumulate_top (
  input  wire                                   clk_i,
  input  wire                                   rst_ni,
  input  wire                                   start,
  output logic                                  busy,
  input  wire  scma_pkg::in_word_t              in_word_i,
  output logic                                  out_valid_o,
  output scma_pkg::out_word_t                   out_word_o,
  input  wire                                   psel,
  input  wire                                   penable,
  input  wire                                   pwrite,
  input  wire  [scma_pkg::ADDR_BITS-1:0]        paddr,
  input  wire  [scma_pkg::DATA_BITS-1:0]        pwdata,
  output logic [scma_pkg::DATA_BITS-1:0]        prdata,
  output logic                                  pready
);

  import scma_pkg::*;

  `include "speaker_channel_mix_accumulate_top_defines.svh"

  localparam int unsigned PROD_BITS = SAMPLE_BITS + GAIN_BITS;
  localparam int unsigned PAIR_BITS = SAMPLE_BITS + 1;
  localparam int unsigned SUM_BITS  = SAMPLE_BITS + 3;
  localparam int unsigned SLOTS     = 6;
  localparam logic signed [PROD_BITS-1:0] ROUND_HALF =
    PROD_BITS'(1) << (GAIN_FRAC_BITS - 1);
  localparam logic signed [SUM_BITS-1:0] SAT_HI =
    SUM_BITS'((64'd1 << (SAMPLE_BITS - 1)) - 64'd1);
  localparam logic signed [SUM_BITS-1:0] SAT_LO = -SAT_HI - SUM_BITS'(1);
  localparam logic [SAMPLE_BITS-1:0] OUT_HI = SAT_HI[SAMPLE_BITS-1:0];
  localparam logic [SAMPLE_BITS-1:0] OUT_LO = SAT_LO[SAMPLE_BITS-1:0];

  function automatic logic [CNT_BITS-1:0] clamp_count(input logic [CNT_BITS-1:0] c);
    logic [CNT_BITS-1:0] r;
    r = c;
    if (c == '0) begin
      r = CNT_BITS'(1);
    end else if (c > CNT_BITS'(MAX_CHANNELS)) begin
      r = CNT_BITS'(MAX_CHANNELS);
    end
    return r;
  endfunction

  // configuration registers
  logic [CNT_BITS-1:0] src_cnt_q, dst_cnt_q;
  logic                mix_mode_q;
  logic                cfg_wr;

  assign pready = 1'b1;
  assign busy   = 1'b0;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_cnt_q  <= SRC_COUNT_RST;
      dst_cnt_q  <= DST_COUNT_RST;
      mix_mode_q <= 1'b0;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_SRC_COUNT: src_cnt_q  <= pwdata[CNT_BITS-1:0];
        REG_DST_COUNT: dst_cnt_q  <= pwdata[CNT_BITS-1:0];
        REG_MIX_MODE:  mix_mode_q <= pwdata[0];
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    prdata = '0;
    unique case (paddr[3:2])
      REG_SRC_COUNT: prdata = DATA_BITS'(src_cnt_q);
      REG_DST_COUNT: prdata = DATA_BITS'(dst_cnt_q);
      REG_MIX_MODE:  prdata = DATA_BITS'(mix_mode_q);
      default:       prdata = '0;
    endcase
  end

  // matrix decode from the channel counts
  logic [CNT_BITS-1:0] ns, nd;
  mix_ctrl_t           ctrl_d;

  always_comb begin
    ns            = clamp_count(src_cnt_q);
    nd            = clamp_count(dst_cnt_q);
    ctrl_d.n_dst  = nd;
    ctrl_d.n_disc = (ns < nd) ? ns : nd;
    priority if (mix_mode_q || ns == nd) begin
      ctrl_d.sel = MIX_DISCRETE;
    end else if (ns == 3'd1 && (nd == 3'd2 || nd == 3'd4)) begin
      ctrl_d.sel = MIX_UP_1_2;
    end else if (ns == 3'd1 && nd == 3'd6) begin
      ctrl_d.sel = MIX_UP_1_6;
    end else if (ns == 3'd2 && (nd == 3'd4 || nd == 3'd6)) begin
      // stereo up-mix matches the first two lanes summed in place
      ctrl_d.sel = MIX_DISCRETE;
    end else if (ns == 3'd4 && nd == 3'd6) begin
      ctrl_d.sel = MIX_UP_4_6;
    end else if (ns == 3'd2 && nd == 3'd1) begin
      ctrl_d.sel = MIX_DN_2_1;
    end else if (ns == 3'd4 && nd == 3'd1) begin
      ctrl_d.sel = MIX_DN_4_1;
    end else if (ns == 3'd6 && nd == 3'd1) begin
      ctrl_d.sel = MIX_DN_6_1;
    end else if (ns == 3'd4 && nd == 3'd2) begin
      ctrl_d.sel = MIX_DN_4_2;
    end else if (ns == 3'd6 && nd == 3'd2) begin
      ctrl_d.sel = MIX_DN_6_2;
    end else if (ns == 3'd6 && nd == 3'd4) begin
      ctrl_d.sel = MIX_DN_6_4;
    end else begin
      ctrl_d.sel = MIX_DISCRETE;
    end
  end

  // pipe valid bits
  logic v1_q, v2_q, v3_q, v4_q, out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      v4_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      v1_q        <= start && !busy;
      v2_q        <= v1_q;
      v3_q        <= v2_q;
      v4_q        <= v3_q;
      out_valid_q <= v4_q;
    end
  end

  // stage 1: capture word and decoded matrix
  logic signed [SAMPLE_BITS-1:0] s1_src_q [LANES];
  logic signed [SAMPLE_BITS-1:0] s1_dst_q [LANES];
  mix_ctrl_t                     s1_ctrl_q;

  always_ff @(posedge clk_i) begin
    if (start && !busy) begin
      s1_src_q[0] <= in_word_i.src_s0;
      s1_src_q[1] <= in_word_i.src_s1;
      s1_src_q[2] <= in_word_i.src_s2;
      s1_src_q[3] <= in_word_i.src_s3;
      s1_src_q[4] <= in_word_i.src_s4;
      s1_src_q[5] <= in_word_i.src_s5;
      s1_dst_q[0] <= in_word_i.dst_s0;
      s1_dst_q[1] <= in_word_i.dst_s1;
      s1_dst_q[2] <= in_word_i.dst_s2;
      s1_dst_q[3] <= in_word_i.dst_s3;
      s1_dst_q[4] <= in_word_i.dst_s4;
      s1_dst_q[5] <= in_word_i.dst_s5;
      s1_ctrl_q   <= ctrl_d;
    end
  end

  // stage 2: sqrt(0.5) products
  logic signed [SAMPLE_BITS-1:0] s2_src_q  [LANES];
  logic signed [SAMPLE_BITS-1:0] s2_dst_q  [LANES];
  logic signed [PROD_BITS-1:0]   s2_prod_q [LANES];
  mix_ctrl_t                     s2_ctrl_q;

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < LANES; k++) begin
      s2_src_q[k]  <= s1_src_q[k];
      s2_dst_q[k]  <= s1_dst_q[k];
      s2_prod_q[k] <= PROD_BITS'(s1_src_q[k]) * PROD_BITS'(GAIN_SQRT_HALF);
    end
    s2_ctrl_q <= s1_ctrl_q;
  end

  // stage 3: round half up each scaled term
  logic signed [SAMPLE_BITS:0]   half_w [LANES];
  logic signed [SAMPLE_BITS:0]   qtr_w  [LANES];
  logic signed [PROD_BITS-1:0]   rt_w   [LANES];
  logic signed [SAMPLE_BITS-1:0] s3_src_q  [LANES];
  logic signed [SAMPLE_BITS-1:0] s3_dst_q  [LANES];
  logic signed [SAMPLE_BITS-1:0] s3_half_q [LANES];
  logic signed [SAMPLE_BITS-1:0] s3_qtr_q  [LANES];
  logic signed [SAMPLE_BITS-1:0] s3_rt_q   [LANES];
  mix_ctrl_t                     s3_ctrl_q;

  always_comb begin
    for (int k = 0; k < LANES; k++) begin
      half_w[k] = {s2_src_q[k][SAMPLE_BITS-1], s2_src_q[k]} + PAIR_BITS'(1);
      qtr_w[k]  = {s2_src_q[k][SAMPLE_BITS-1], s2_src_q[k]} + PAIR_BITS'(2);
      rt_w[k]   = s2_prod_q[k] + ROUND_HALF;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < LANES; k++) begin
      s3_src_q[k]  <= s2_src_q[k];
      s3_dst_q[k]  <= s2_dst_q[k];
      s3_half_q[k] <= half_w[k][SAMPLE_BITS:1];
      s3_qtr_q[k]  <= {qtr_w[k][SAMPLE_BITS], qtr_w[k][SAMPLE_BITS:2]};
      s3_rt_q[k]   <= rt_w[k][GAIN_FRAC_BITS+SAMPLE_BITS-1:GAIN_FRAC_BITS];
    end
    s3_ctrl_q <= s2_ctrl_q;
  end

  // stage 4: matrix term select and pair sums
  logic signed [SAMPLE_BITS-1:0] term [LANES][SLOTS];
  logic signed [PAIR_BITS-1:0]   s4_pa_q [LANES];
  logic signed [PAIR_BITS-1:0]   s4_pb_q [LANES];
  logic signed [PAIR_BITS-1:0]   s4_pc_q [LANES];
  mix_ctrl_t                     s4_ctrl_q;

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      for (int j = 0; j < SLOTS; j++) begin
        term[i][j] = '0;
      end
      term[i][0] = s3_dst_q[i];
    end
    unique case (s3_ctrl_q.sel)
      MIX_DISCRETE: begin
        for (int i = 0; i < LANES; i++) begin
          if (CNT_BITS'(i) < s3_ctrl_q.n_disc) begin
            term[i][1] = s3_src_q[i];
          end
        end
      end
      MIX_UP_1_2: begin
        term[0][1] = s3_src_q[0];
        term[1][1] = s3_src_q[0];
      end
      MIX_UP_1_6: begin
        term[2][1] = s3_src_q[0];
      end
      MIX_UP_4_6: begin
        term[0][1] = s3_src_q[0];
        term[1][1] = s3_src_q[1];
        term[4][1] = s3_src_q[2];
        term[5][1] = s3_src_q[3];
      end
      MIX_DN_2_1: begin
        term[0][1] = s3_half_q[0];
        term[0][2] = s3_half_q[1];
      end
      MIX_DN_4_1: begin
        term[0][1] = s3_qtr_q[0];
        term[0][2] = s3_qtr_q[1];
        term[0][3] = s3_qtr_q[2];
        term[0][4] = s3_qtr_q[3];
      end
      MIX_DN_6_1: begin
        term[0][1] = s3_rt_q[0];
        term[0][2] = s3_rt_q[1];
        term[0][3] = s3_src_q[2];
        term[0][4] = s3_half_q[4];
        term[0][5] = s3_half_q[5];
      end
      MIX_DN_4_2: begin
        term[0][1] = s3_half_q[0];
        term[0][2] = s3_half_q[2];
        term[1][1] = s3_half_q[1];
        term[1][2] = s3_half_q[3];
      end
      MIX_DN_6_2: begin
        term[0][1] = s3_src_q[0];
        term[0][2] = s3_rt_q[2];
        term[0][3] = s3_rt_q[4];
        term[1][1] = s3_src_q[1];
        term[1][2] = s3_rt_q[2];
        term[1][3] = s3_rt_q[5];
      end
      MIX_DN_6_4: begin
        term[0][1] = s3_src_q[0];
        term[0][2] = s3_rt_q[2];
        term[1][1] = s3_src_q[1];
        term[1][2] = s3_rt_q[2];
        term[2][1] = s3_src_q[4];
        term[3][1] = s3_src_q[5];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < LANES; i++) begin
      s4_pa_q[i] <= PAIR_BITS'(term[i][0]) + PAIR_BITS'(term[i][1]);
      s4_pb_q[i] <= PAIR_BITS'(term[i][2]) + PAIR_BITS'(term[i][3]);
      s4_pc_q[i] <= PAIR_BITS'(term[i][4]) + PAIR_BITS'(term[i][5]);
    end
    s4_ctrl_q <= s3_ctrl_q;
  end

  // stage 5: final sum, saturation and unused lanes
  logic signed [SUM_BITS-1:0]    total [LANES];
  logic signed [SAMPLE_BITS-1:0] lane_d [LANES];
  logic        [LANES-1:0]       lane_clip;
  logic signed [SAMPLE_BITS-1:0] out_q [LANES];
  logic                          clip_q;
  logic        [CNT_BITS-1:0]    out_ndst_q;

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      total[i] = SUM_BITS'(s4_pa_q[i]) + SUM_BITS'(s4_pb_q[i]) + SUM_BITS'(s4_pc_q[i]);
      lane_clip[i] = 1'b0;
      lane_d[i]    = total[i][SAMPLE_BITS-1:0];
      if (CNT_BITS'(i) >= s4_ctrl_q.n_dst) begin
        lane_d[i] = '0;
      end else if (total[i] > SAT_HI) begin
        lane_d[i]    = OUT_HI;
        lane_clip[i] = 1'b1;
      end else if (total[i] < SAT_LO) begin
        lane_d[i]    = OUT_LO;
        lane_clip[i] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < LANES; i++) begin
      out_q[i] <= lane_d[i];
    end
    clip_q     <= |lane_clip;
    out_ndst_q <= s4_ctrl_q.n_dst;
  end

  assign out_valid_o        = out_valid_q;
  assign out_word_o.out_s0  = out_q[0];
  assign out_word_o.out_s1  = out_q[1];
  assign out_word_o.out_s2  = out_q[2];
  assign out_word_o.out_s3  = out_q[3];
  assign out_word_o.out_s4  = out_q[4];
  assign out_word_o.out_s5  = out_q[5];
  assign out_word_o.clipped = clip_q;

  // some lane sits on a rail
  logic out_at_rail;

  always_comb begin
    out_at_rail = 1'b0;
    for (int i = 0; i < LANES; i++) begin
      if (out_q[i] == OUT_HI || out_q[i] == OUT_LO) begin
        out_at_rail = 1'b1;
      end
    end
  end

  `SCMA_ASSERT(a_latency, start && !busy |-> ##5 out_valid_o,
               "accepted word did not come out five cycles later")
  `SCMA_ASSERT(a_clip_rail, out_valid_o && out_word_o.clipped |-> out_at_rail,
               "clipped flagged without a saturated lane")
  `SCMA_ASSERT(a_unused_zero, out_valid_o && out_ndst_q <= CNT_BITS'(1) |->
               out_word_o.out_s1 == '0 && out_word_o.out_s5 == '0,
               "unused destination lane not zero")
  `SCMA_ASSERT_ALWAYS(a_rst_quiet, !rst_ni |-> !out_valid_o,
                      "result strobe during reset")

endmodule

`default_nettype wire

### test/speaker_mix_scoreboard.sv
`timescale 1ns / 1ps

// watches the mixer ports, predicts every result word and compares it
module speaker_mix_scoreboard (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  input  wire                               start_i,
  input  wire                               busy_i,
  input  scma_pkg::in_word_t                in_word_i,
  input  wire                               res_valid_i,
  input  scma_pkg::out_word_t               res_word_i,
  input  wire                               psel_i,
  input  wire                               penable_i,
  input  wire                               pwrite_i,
  input  wire                               pready_i,
  input  wire  [scma_pkg::ADDR_BITS-1:0]    paddr_i,
  input  wire  [scma_pkg::DATA_BITS-1:0]    pwdata_i,
  output int                                fail_count_o,
  output int                                words_due_o
);

  import scma_pkg::*;

  localparam logic MODE_SPEAKERS = 1'b0;
  localparam logic MODE_DISCRETE = 1'b1;

  localparam longint GAIN_Q_HALF    = 16384;
  localparam longint GAIN_Q_QUARTER = 8192;
  localparam longint GAIN_Q_SQRT    = longint'(GAIN_SQRT_HALF);
  localparam longint ROUND_HALF     = longint'(1) << (GAIN_FRAC_BITS - 1);
  localparam longint SAT_HI         = (longint'(1) << (SAMPLE_BITS - 1)) - 1;
  localparam longint SAT_LO         = -SAT_HI - 1;

  // shadow copy of the register file
  logic [CNT_BITS-1:0] src_cnt  = SRC_COUNT_RST;
  logic [CNT_BITS-1:0] dst_cnt  = DST_COUNT_RST;
  logic                mix_mode = MODE_SPEAKERS;

  out_word_t mix_due_q[$];
  out_word_t want;
  int        errs = 0;
  logic      bad;

  // zero reads as mono, anything past six as six
  function automatic int fit_count(input logic [CNT_BITS-1:0] c);
    if (c == 0) return 1;
    if (c > MAX_CHANNELS) return MAX_CHANNELS;
    return int'(c);
  endfunction

  // q1.15 gain, rounded half up with floor
  function automatic longint gain_term(input longint x, input longint g);
    return (x * g + ROUND_HALF) >>> GAIN_FRAC_BITS;
  endfunction

  // new destination frame for one input word under the current registers
  function automatic out_word_t mix_frame(input in_word_t w);
    longint                        s [LANES];
    longint                        d [LANES];
    logic signed [SAMPLE_BITS-1:0] lane [LANES];
    out_word_t                     r;
    int                            ns;
    int                            nd;
    mix_sel_e                      sel;
    logic                          clip;
    s[0] = $signed(w.src_s0); s[1] = $signed(w.src_s1); s[2] = $signed(w.src_s2);
    s[3] = $signed(w.src_s3); s[4] = $signed(w.src_s4); s[5] = $signed(w.src_s5);
    d[0] = $signed(w.dst_s0); d[1] = $signed(w.dst_s1); d[2] = $signed(w.dst_s2);
    d[3] = $signed(w.dst_s3); d[4] = $signed(w.dst_s4); d[5] = $signed(w.dst_s5);
    ns   = fit_count(src_cnt);
    nd   = fit_count(dst_cnt);
    clip = 1'b0;

    // pick the layout matrix; 2 to 4 and 2 to 6 equal the discrete sum
    sel = MIX_DISCRETE;
    if (mix_mode == MODE_SPEAKERS && ns != nd) begin
      if (ns == 1 && (nd == 2 || nd == 4)) sel = MIX_UP_1_2;
      else if (ns == 1 && nd == 6) sel = MIX_UP_1_6;
      else if (ns == 4 && nd == 6) sel = MIX_UP_4_6;
      else if (ns == 2 && nd == 1) sel = MIX_DN_2_1;
      else if (ns == 4 && nd == 1) sel = MIX_DN_4_1;
      else if (ns == 6 && nd == 1) sel = MIX_DN_6_1;
      else if (ns == 4 && nd == 2) sel = MIX_DN_4_2;
      else if (ns == 6 && nd == 2) sel = MIX_DN_6_2;
      else if (ns == 6 && nd == 4) sel = MIX_DN_6_4;
    end

    case (sel)
      MIX_UP_1_2: begin
        d[0] += s[0];
        d[1] += s[0];
      end
      MIX_UP_1_6: begin
        d[2] += s[0];
      end
      MIX_UP_4_6: begin
        d[0] += s[0];
        d[1] += s[1];
        d[4] += s[2];
        d[5] += s[3];
      end
      MIX_DN_2_1: begin
        d[0] += gain_term(s[0], GAIN_Q_HALF) + gain_term(s[1], GAIN_Q_HALF);
      end
      MIX_DN_4_1: begin
        d[0] += gain_term(s[0], GAIN_Q_QUARTER) + gain_term(s[1], GAIN_Q_QUARTER)
              + gain_term(s[2], GAIN_Q_QUARTER) + gain_term(s[3], GAIN_Q_QUARTER);
      end
      MIX_DN_6_1: begin
        d[0] += gain_term(s[0], GAIN_Q_SQRT) + gain_term(s[1], GAIN_Q_SQRT) + s[2]
              + gain_term(s[4], GAIN_Q_HALF) + gain_term(s[5], GAIN_Q_HALF);
      end
      MIX_DN_4_2: begin
        d[0] += gain_term(s[0], GAIN_Q_HALF) + gain_term(s[2], GAIN_Q_HALF);
        d[1] += gain_term(s[1], GAIN_Q_HALF) + gain_term(s[3], GAIN_Q_HALF);
      end
      MIX_DN_6_2: begin
        d[0] += s[0] + gain_term(s[2], GAIN_Q_SQRT) + gain_term(s[4], GAIN_Q_SQRT);
        d[1] += s[1] + gain_term(s[2], GAIN_Q_SQRT) + gain_term(s[5], GAIN_Q_SQRT);
      end
      MIX_DN_6_4: begin
        d[0] += s[0] + gain_term(s[2], GAIN_Q_SQRT);
        d[1] += s[1] + gain_term(s[2], GAIN_Q_SQRT);
        d[2] += s[4];
        d[3] += s[5];
      end
      default: begin
        for (int i = 0; i < LANES; i++) begin
          if (i < ns && i < nd) d[i] += s[i];
        end
      end
    endcase

    // saturate lanes in use, zero the rest
    for (int i = 0; i < LANES; i++) begin
      if (i >= nd) begin
        lane[i] = '0;
      end else if (d[i] > SAT_HI) begin
        lane[i] = SAT_HI[SAMPLE_BITS-1:0];
        clip    = 1'b1;
      end else if (d[i] < SAT_LO) begin
        lane[i] = SAT_LO[SAMPLE_BITS-1:0];
        clip    = 1'b1;
      end else begin
        lane[i] = d[i][SAMPLE_BITS-1:0];
      end
    end
    r.out_s0  = lane[0];
    r.out_s1  = lane[1];
    r.out_s2  = lane[2];
    r.out_s3  = lane[3];
    r.out_s4  = lane[4];
    r.out_s5  = lane[5];
    r.clipped = clip;
    return r;
  endfunction

  // register writes, accepted words and result words, all sampled at the edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        case (paddr_i[3:2])
          REG_SRC_COUNT: src_cnt = pwdata_i[CNT_BITS-1:0];
          REG_DST_COUNT: dst_cnt = pwdata_i[CNT_BITS-1:0];
          REG_MIX_MODE:  mix_mode = pwdata_i[0] ? MODE_DISCRETE : MODE_SPEAKERS;
          default: ;
        endcase
      end

      if (start_i && !busy_i) mix_due_q.push_back(mix_frame(in_word_i));

      if (res_valid_i) begin
        if (mix_due_q.size() == 0) begin
          $display("%0t: result word with nothing due, actual %h", $time, res_word_i);
          errs++;
        end else begin
          want = mix_due_q.pop_front();
          bad  = 1'b0;
          for (int k = 0; k < LANES; k++) begin
            if (want[1 + (LANES-1-k)*SAMPLE_BITS +: SAMPLE_BITS] !==
                res_word_i[1 + (LANES-1-k)*SAMPLE_BITS +: SAMPLE_BITS]) begin
              $display("%0t: out_s%0d expected %0d actual %0d", $time, k,
                       $signed(want[1 + (LANES-1-k)*SAMPLE_BITS +: SAMPLE_BITS]),
                       $signed(res_word_i[1 + (LANES-1-k)*SAMPLE_BITS +: SAMPLE_BITS]));
              bad = 1'b1;
            end
          end
          if (want.clipped !== res_word_i.clipped) begin
            $display("%0t: clipped expected %b actual %b", $time, want.clipped,
                     res_word_i.clipped);
            bad = 1'b1;
          end
          if (bad) errs++;
        end
      end

      fail_count_o <= errs;
      words_due_o  <= mix_due_q.size();
    end
  end

endmodule

### test/tb_speaker_channel_mix_accumulate_top.sv
`timescale 1ns / 1ps

module tb_speaker_channel_mix_accumulate_top;
  import scma_pkg::*;

  localparam int WATCHDOG_LIMIT = 400;
  localparam int DRAIN_PAD      = 8;
  localparam int TAIL_PAD       = 20;
  localparam int FRAMES_PER_MIX = 10;

  localparam logic [1:0] REG_SPARE = 2'd3;

  localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  logic                 clk_i;
  logic                 rst_ni;
  logic                 start;
  logic                 busy;
  in_word_t             in_word;
  logic                 out_valid;
  out_word_t            out_word;
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [ADDR_BITS-1:0] paddr;
  logic [DATA_BITS-1:0] pwdata;
  logic [DATA_BITS-1:0] prdata;
  logic                 pready;

  int fail_count;
  int words_due;
  int quiet_cycles = 0;
  int burst_left   = 0;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  speaker_channel_mix_accumulate_top uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .in_word_i   (in_word),
    .out_valid_o (out_valid),
    .out_word_o  (out_word),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  speaker_mix_scoreboard u_scoreboard (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start),
    .busy_i       (busy),
    .in_word_i    (in_word),
    .res_valid_i  (out_valid),
    .res_word_i   (out_word),
    .psel_i       (psel),
    .penable_i    (penable),
    .pwrite_i     (pwrite),
    .pready_i     (pready),
    .paddr_i      (paddr),
    .pwdata_i     (pwdata),
    .fail_count_o (fail_count),
    .words_due_o  (words_due)
  );

  // watchdog on cycles where no word moves
  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || out_valid) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // sample biased toward full scale, zero and small values
  function automatic logic [SAMPLE_BITS-1:0] pick_sample();
    logic [SAMPLE_BITS-1:0] v;
    v = SAMPLE_BITS'($urandom());
    case ($urandom_range(0, 9))
      0: v = SAMPLE_MAX;
      1: v = SAMPLE_MIN;
      2: v = '0;
      3: v = '1;
      4: v = SAMPLE_MAX - SAMPLE_BITS'($urandom_range(0, 255));
      5: v = SAMPLE_MIN + SAMPLE_BITS'($urandom_range(0, 255));
      6: v = SAMPLE_BITS'($urandom_range(0, 511) - 256);
      default: ;
    endcase
    return v;
  endfunction

  function automatic in_word_t random_frame();
    in_word_t w;
    w.src_s0 = pick_sample(); w.src_s1 = pick_sample(); w.src_s2 = pick_sample();
    w.src_s3 = pick_sample(); w.src_s4 = pick_sample(); w.src_s5 = pick_sample();
    w.dst_s0 = pick_sample(); w.dst_s1 = pick_sample(); w.dst_s2 = pick_sample();
    w.dst_s3 = pick_sample(); w.dst_s4 = pick_sample(); w.dst_s5 = pick_sample();
    return w;
  endfunction

  // every source lane one value, every destination lane another
  function automatic in_word_t flat_frame(input logic [SAMPLE_BITS-1:0] sv,
                                          input logic [SAMPLE_BITS-1:0] dv);
    in_word_t w;
    w.src_s0 = sv; w.src_s1 = sv; w.src_s2 = sv;
    w.src_s3 = sv; w.src_s4 = sv; w.src_s5 = sv;
    w.dst_s0 = dv; w.dst_s1 = dv; w.dst_s2 = dv;
    w.dst_s3 = dv; w.dst_s4 = dv; w.dst_s5 = dv;
    return w;
  endfunction

  // hold start low for a rest of length n, n above zero
  task automatic rest_cycles(input int n);
    start <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  // offer one word and wait for the accepting edge; start stays high
  task automatic push_word(input in_word_t w);
    in_word <= w;
    start   <= 1'b1;
    do @(posedge clk_i); while (busy);
  endtask

  // words go out in bursts of random length with random gaps between them
  task automatic send_frame(input in_word_t w);
    int gap;
    push_word(w);
    burst_left--;
    if (burst_left <= 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
      if (gap > 0) rest_cycles(gap);
      burst_left = ($urandom_range(0, 7) == 0) ? 40 : $urandom_range(1, 12);
    end
  endtask

  // stop sending and wait until every due result word has arrived
  task automatic drain();
    start <= 1'b0;
    @(posedge clk_i);
    while (words_due != 0) @(posedge clk_i);
    repeat (DRAIN_PAD) @(posedge clk_i);
  endtask

  // apb write: setup, access until pready, then idle
  task automatic reg_write(input logic [1:0] idx, input logic [DATA_BITS-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_BITS'({idx, 2'b00});
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  // new channel counts and mode, junk in the upper data bits
  task automatic set_mix(input int ns, input int nd, input logic discrete);
    logic [DATA_BITS-1:0] junk;
    drain();
    junk = $urandom();
    reg_write(REG_SRC_COUNT, {junk[DATA_BITS-1:CNT_BITS], CNT_BITS'(ns)});
    junk = $urandom();
    reg_write(REG_DST_COUNT, {junk[DATA_BITS-1:CNT_BITS], CNT_BITS'(nd)});
    junk = $urandom();
    reg_write(REG_MIX_MODE, {junk[DATA_BITS-1:1], discrete});
    if ($urandom_range(0, 3) == 0) reg_write(REG_SPARE, $urandom());
  endtask

  initial begin
    rst_ni  = 1'b0;
    start   = 1'b0;
    in_word = '0;
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = '0;
    pwdata  = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset layout, stereo into stereo: extremes and saturation both ways
    send_frame(flat_frame('0, '0));
    send_frame(flat_frame(SAMPLE_MAX, SAMPLE_MAX));
    send_frame(flat_frame(SAMPLE_MIN, SAMPLE_MIN));
    send_frame(flat_frame(SAMPLE_MAX, SAMPLE_MIN));
    send_frame(flat_frame(SAMPLE_BITS'(1), SAMPLE_MAX));
    send_frame(flat_frame('1, SAMPLE_MIN));
    send_frame(flat_frame({(SAMPLE_BITS/2){2'b10}}, {(SAMPLE_BITS/2){2'b01}}));

    // 5.1 into mono: every gain, rounding of small and full scale terms
    set_mix(6, 1, 1'b0);
    send_frame(flat_frame('1, '0));
    send_frame(flat_frame(SAMPLE_BITS'(1), '0));
    send_frame(flat_frame(SAMPLE_BITS'(3), '0));
    send_frame(flat_frame(SAMPLE_MAX, '0));
    send_frame(flat_frame(SAMPLE_MIN, '0));
    send_frame(flat_frame(SAMPLE_MAX, SAMPLE_MAX));
    send_frame(flat_frame(SAMPLE_MIN, SAMPLE_MIN));
    send_frame(random_frame());
    send_frame(random_frame());

    // every raw count pair, zero and seven included, mostly speaker layouts
    for (int ns = 0; ns < 8; ns++) begin
      for (int nd = 0; nd < 8; nd++) begin
        set_mix(ns, nd, ($urandom_range(0, 3) == 0) || (ns == 7 && nd == 0));
        for (int n = 0; n < FRAMES_PER_MIX; n++) send_frame(random_frame());
      end
    end

    start <= 1'b0;
    @(posedge clk_i);
    while (words_due != 0) @(posedge clk_i);
    repeat (TAIL_PAD) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

### speaker_channel_mix_accumulate_top.f
+incdir+rtl
rtl/scma_pkg.sv
rtl/speaker_channel_mix_accumulate_top.sv
test/speaker_mix_scoreboard.sv
test/tb_speaker_channel_mix_accumulate_top.sv
